/* rtl/core/bvfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector find and count package
// Request codes, field widths and the result record shared by the core files.
// ----------------------------------------------------------------------------
package bvfc_pkg;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned SH_W  = 9;
  localparam int unsigned CNT_W = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_QUERY      = 3'd0,
    REQ_SET        = 3'd1,
    REQ_CLEAR      = 3'd2,
    REQ_FLIP       = 3'd3,
    REQ_SET_ALL    = 3'd4,
    REQ_CLEAR_ALL  = 3'd5,
    REQ_SHIFT_UP   = 3'd6,
    REQ_SHIFT_DOWN = 3'd7
  } req_type_e;

  typedef struct packed {
    logic             bit_value;
    logic [CNT_W-1:0] ones_count;
    logic             any_set;
    logic             all_set;
    logic [IDX_W-1:0] low_set_index;
    logic             low_set_found;
    logic [IDX_W-1:0] low_clear_index;
    logic             low_clear_found;
    logic [IDX_W-1:0] high_set_index;
    logic             high_set_found;
    logic [IDX_W-1:0] high_clear_index;
    logic             high_clear_found;
  } result_t;

endpackage

/* rtl/core/bvfc_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector store
// Holds the vector and applies one update per accepted request, capturing the
// selected bit position for the report stage.
// ----------------------------------------------------------------------------
module bvfc_store
  import bvfc_pkg::*;
#(
  parameter int unsigned BITS = 256,
  parameter int unsigned SW   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [IDX_W-1:0] bit_index_i,
  input  logic [SH_W-1:0]  shift_amount_i,
  output logic [BITS-1:0]  vec_o,
  output logic             in_range_o,
  output logic [SW-1:0]    sel_o
);

  logic [BITS-1:0] vec_q, vec_d;
  logic [SW-1:0]   sel_q;
  logic            in_range_q;
  logic [SW-1:0]   sel;
  logic            in_range;
  logic [BITS-1:0] mask;

  assign in_range = (32'(bit_index_i) < BITS);
  assign sel      = SW'(bit_index_i);
  assign mask     = BITS'(1) << sel;

  always_comb begin
    vec_d = vec_q;
    unique case (req_type_e'(req_type_i))
      REQ_QUERY:      vec_d = vec_q;
      REQ_SET:        if (in_range) vec_d = vec_q | mask;
      REQ_CLEAR:      if (in_range) vec_d = vec_q & ~mask;
      REQ_FLIP:       if (in_range) vec_d = vec_q ^ mask;
      REQ_SET_ALL:    vec_d = '1;
      REQ_CLEAR_ALL:  vec_d = '0;
      REQ_SHIFT_UP:   vec_d = vec_q << shift_amount_i;
      REQ_SHIFT_DOWN: vec_d = vec_q >> shift_amount_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (take_i) begin
      vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      sel_q      <= sel;
      in_range_q <= in_range;
    end
  end

  assign vec_o      = vec_q;
  assign in_range_o = in_range_q;
  assign sel_o      = sel_q;

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && req_type_i == REQ_CLEAR_ALL |=> vec_q == '0)
    else $error("Vector not cleared after a clear-all request.");

  a_set_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && req_type_i == REQ_SET_ALL |=> &vec_q)
    else $error("Vector not filled after a set-all request.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> $stable(vec_q))
    else $error("Vector changed without an accepted request.");

endmodule

/* rtl/core/bvfc_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector scan
// Population count, any and all flags, and the four first and last searches
// over the stored vector.
// ----------------------------------------------------------------------------
module bvfc_scan
  import bvfc_pkg::*;
#(
  parameter int unsigned BITS = 256,
  parameter int unsigned SW   = 8
) (
  input  logic [BITS-1:0] vec_i,
  input  logic            in_range_i,
  input  logic [SW-1:0]   sel_i,
  output result_t         res_o
);

  localparam int unsigned PW = $clog2(BITS + 1);
  localparam int unsigned LV = (BITS > 1) ? $clog2(BITS) : 0;
  localparam int unsigned NP = 1 << LV;

  logic [PW-1:0]    ones;
  logic [IDX_W-1:0] lo_s, lo_c, hi_s, hi_c;
  logic [NP-1:0]    vec_pad;
  logic [PW-1:0]    tree [0:2*NP-2];

  assign vec_pad = NP'(vec_i);

  // The count is a balanced adder tree: leaves hold single bits and each
  // node adds its two children.
  always_comb begin
    for (int i = 0; i < int'(NP); i++) begin
      tree[int'(NP) - 1 + i] = PW'(vec_pad[i]);
    end
    for (int i = int'(NP) - 2; i >= 0; i--) begin
      tree[i] = tree[2*i+1] + tree[2*i+2];
    end
  end

  assign ones = tree[0];

  always_comb begin
    lo_s = '0;
    lo_c = '0;
    for (int i = BITS - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        lo_s = IDX_W'(i);
      end else begin
        lo_c = IDX_W'(i);
      end
    end
  end

  always_comb begin
    hi_s = '0;
    hi_c = '0;
    for (int i = 0; i < BITS; i++) begin
      if (vec_i[i]) begin
        hi_s = IDX_W'(i);
      end else begin
        hi_c = IDX_W'(i);
      end
    end
  end

  always_comb begin
    res_o                  = '0;
    res_o.bit_value        = in_range_i & vec_i[sel_i];
    res_o.ones_count       = CNT_W'(ones);
    res_o.any_set          = |vec_i;
    res_o.all_set          = &vec_i;
    res_o.low_set_index    = lo_s;
    res_o.low_set_found    = |vec_i;
    res_o.low_clear_index  = lo_c;
    res_o.low_clear_found  = ~&vec_i;
    res_o.high_set_index   = hi_s;
    res_o.high_set_found   = |vec_i;
    res_o.high_clear_index = hi_c;
    res_o.high_clear_found = ~&vec_i;
  end

endmodule

/* rtl/core/bit_vector_with_find_and_count_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector with find and count
// Keeps a bit vector that each request may update, then reports the selected
// bit, the ones count and the lowest and highest set and clear positions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid_i/in_ready_o   req_type, bit_index, shift_amount
//  out       output     out_valid_o/out_ready_i bit_value, ones_count, flags, indices
//
// One request is accepted per cycle while in_ready_o is high; the store registers
// the updated vector, and the output register then captures the scan result.
// The vector is updated at acceptance; the scan stage reads the stored vector.
// Reset clears the vector and both stage valid flags at once.
// A stalled result holds the scan stage, and ready falls back to the input.
// ----------------------------------------------------------------------------
module bit_vector_with_find_and_count_top
  import bvfc_pkg::*;
#(
  parameter int unsigned BITS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [IDX_W-1:0] bit_index_i,
  input  logic [SH_W-1:0]  shift_amount_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             bit_value_o,
  output logic [CNT_W-1:0] ones_count_o,
  output logic             any_set_o,
  output logic             all_set_o,
  output logic [IDX_W-1:0] low_set_index_o,
  output logic             low_set_found_o,
  output logic [IDX_W-1:0] low_clear_index_o,
  output logic             low_clear_found_o,
  output logic [IDX_W-1:0] high_set_index_o,
  output logic             high_set_found_o,
  output logic [IDX_W-1:0] high_clear_index_o,
  output logic             high_clear_found_o
);

  localparam int unsigned SW = (BITS > 1) ? $clog2(BITS) : 1;

  logic            scan_vld_q;
  logic            out_vld_q;
  logic            out_free;
  logic            scan_free;
  logic            take;
  logic [BITS-1:0] vec;
  logic            in_range;
  logic [SW-1:0]   sel;
  result_t         scan_res;
  result_t         res_q;

  assign out_free   = !out_vld_q || out_ready_i;
  assign scan_free  = !scan_vld_q || out_free;
  assign in_ready_o = scan_free;
  assign take       = in_valid_i && scan_free;

  bvfc_store #(
    .BITS(BITS),
    .SW  (SW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .req_type_i    (req_type_i),
    .bit_index_i   (bit_index_i),
    .shift_amount_i(shift_amount_i),
    .vec_o         (vec),
    .in_range_o    (in_range),
    .sel_o         (sel)
  );

  bvfc_scan #(
    .BITS(BITS),
    .SW  (SW)
  ) u_scan (
    .vec_i     (vec),
    .in_range_i(in_range),
    .sel_i     (sel),
    .res_o     (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (scan_free) begin
        scan_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= scan_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && scan_vld_q) begin
      res_q <= scan_res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign bit_value_o        = res_q.bit_value;
  assign ones_count_o       = res_q.ones_count;
  assign any_set_o          = res_q.any_set;
  assign all_set_o          = res_q.all_set;
  assign low_set_index_o    = res_q.low_set_index;
  assign low_set_found_o    = res_q.low_set_found;
  assign low_clear_index_o  = res_q.low_clear_index;
  assign low_clear_found_o  = res_q.low_clear_found;
  assign high_set_index_o   = res_q.high_set_index;
  assign high_set_found_o   = res_q.high_set_found;
  assign high_clear_index_o = res_q.high_clear_index;
  assign high_clear_found_o = res_q.high_clear_found;

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && low_set_found_o |-> low_set_index_o <= high_set_index_o)
    else $error("Lowest set position lies above the highest one.");

  a_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_set_o |-> !low_clear_found_o && ones_count_o == CNT_W'(BITS))
    else $error("All-set flag disagrees with the count or the clear search.");

  a_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !any_set_o |-> ones_count_o == '0 && !high_set_found_o)
    else $error("Empty vector reported with set bits.");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> scan_vld_q)
    else $error("Accepted request did not reach the scan stage.");

endmodule
